// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL. Empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== src/fr_gcd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fr_gcd_pkg
// Widths, sequencer states and helpers for the fraction reducer.
// ---------------------------------------------------------------------------
package fr_gcd_pkg;

  localparam int unsigned W     = 32;
  localparam int unsigned KW    = 5;   // count of common factors of two
  localparam int unsigned CNT_W = 5;   // divider bit counter

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_GCD    = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_DIVN   = 6'b001000,
    ST_DIVD   = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  // magnitude of a signed word; -2^31 maps to 2^31, which still fits
  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? W'(-x) : x;
  endfunction

  // apply the sign of the original operand to an unsigned quotient
  function automatic logic [W-1:0] apply_sign(input logic neg, input logic [W-1:0] q);
    apply_sign = neg ? W'(-q) : q;
  endfunction

endpackage

// ===== src/fraction_reducer_gcd_core.sv =====
`timescale 1ns / 1ps
// Sequence: the input is captured in ST_IDLE and the binary gcd steps run in ST_GCD,
//   then ST_DECIDE; when the fraction is reduced ST_DIVN and ST_DIVD follow, then
//   ST_FIN; a divisor of one skips both divisions; a zero denominator skips to ST_FIN.
// Flow: one item at a time, the steps sharing one subtractor; the next input is taken
//   once the result is loaded into the output register, without waiting for its transfer.
// Reset: rst is synchronous, active high; clears the sequencer and output valid.
// ---------------------------------------------------------------------------
// fraction_reducer_gcd_core
// Reduces a signed fraction by the gcd of its magnitudes, using one shared
// subtractor for a binary gcd and two restoring divisions.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fraction_reducer_gcd_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] numerator, [63:32] denominator
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] reduced_numerator,
                                 // [63:32] reduced_denominator,
                                 // [95:64] common_divisor
  output logic        m_tuser    // [0] was_reduced
);

  localparam int unsigned W = fr_gcd_pkg::W;

  fr_gcd_pkg::state_t state;

  // held copy of the input fraction
  logic [W-1:0] num, den;
  // gcd working registers
  logic [W-1:0] a, b;
  logic [fr_gcd_pkg::KW-1:0] k;
  logic [W-1:0] g;
  // divider: dvd shifts out dividend bits and takes in quotient bits
  logic [W-1:0] dvd, rem;
  logic [fr_gcd_pkg::CNT_W-1:0] cnt;
  // results waiting for the output register
  logic [W-1:0] rn, rd;
  logic         flag;

  // output register
  logic [W-1:0] out_num, out_den, out_g;
  logic         out_flag, out_valid;

  // ---- shared subtractor ----------------------------------------------------
  // GCD step: a - b. Division step: shifted remainder - divisor.
  logic [W:0]   sub_x;
  logic [W-1:0] sub_y;
  logic [W+1:0] diff;
  logic         ge;
  logic [W:0]   rem_shift;

  assign rem_shift = {rem, dvd[W-1]};

  always_comb begin
    if (state == fr_gcd_pkg::ST_GCD) begin
      sub_x = {1'b0, a};
      sub_y = b;
    end else begin
      sub_x = rem_shift;
      sub_y = g;
    end
    diff = {1'b0, sub_x} - {2'b00, sub_y};
    ge   = ~diff[W+1];
  end

  // b - a when a < b, for the odd/odd gcd step
  logic [W-1:0] diff_neg;
  assign diff_neg = W'(-diff);

  logic [W-1:0] rem_new;
  logic [W-1:0] quo_new;
  assign rem_new = ge ? diff[W-1:0] : rem_shift[W-1:0];
  assign quo_new = {dvd[W-2:0], ge};

  logic last_bit;
  assign last_bit = (cnt == fr_gcd_pkg::CNT_W'(W - 1));

  logic out_free;
  assign out_free = ~out_valid | m_tready;

  assign s_tready = (state == fr_gcd_pkg::ST_IDLE);

  // ---- sequencer ------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fr_gcd_pkg::ST_IDLE;
    end else begin
      case (state)
        fr_gcd_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            num  <= s_tdata[31:0];
            den  <= s_tdata[63:32];
            a    <= fr_gcd_pkg::mag(s_tdata[31:0]);
            b    <= fr_gcd_pkg::mag(s_tdata[63:32]);
            k    <= '0;
            rn   <= s_tdata[31:0];
            rd   <= s_tdata[63:32];
            flag <= 1'b0;
            g    <= '0;
            if (s_tdata[63:32] == '0) begin
              state <= fr_gcd_pkg::ST_FIN;   // zero denominator: pass through
            end else begin
              state <= fr_gcd_pkg::ST_GCD;
            end
          end
        end
        fr_gcd_pkg::ST_GCD: begin
          // Stein's algorithm, one step per cycle; b stays nonzero throughout
          if (a == '0) begin
            g     <= b << k;
            state <= fr_gcd_pkg::ST_DECIDE;
          end else if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + 1'b1;
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (ge) begin
            a <= diff[W-1:0] >> 1;
          end else begin
            b <= diff_neg >> 1;
          end
        end
        fr_gcd_pkg::ST_DECIDE: begin
          if (g > W'(1)) begin
            flag  <= 1'b1;
            dvd   <= fr_gcd_pkg::mag(num);
            rem   <= '0;
            cnt   <= '0;
            state <= fr_gcd_pkg::ST_DIVN;
          end else begin
            state <= fr_gcd_pkg::ST_FIN;
          end
        end
        fr_gcd_pkg::ST_DIVN: begin
          cnt <= cnt + 1'b1;
          if (last_bit) begin
            rn    <= fr_gcd_pkg::apply_sign(num[W-1], quo_new);
            dvd   <= fr_gcd_pkg::mag(den);
            rem   <= '0;
            state <= fr_gcd_pkg::ST_DIVD;
          end else begin
            dvd <= quo_new;
            rem <= rem_new;
          end
        end
        fr_gcd_pkg::ST_DIVD: begin
          dvd <= quo_new;
          rem <= rem_new;
          cnt <= cnt + 1'b1;
          if (last_bit) begin
            rd    <= fr_gcd_pkg::apply_sign(den[W-1], quo_new);
            state <= fr_gcd_pkg::ST_FIN;
          end
        end
        fr_gcd_pkg::ST_FIN: begin
          // wait for the output register to free up, then hand over
          if (out_free) begin
            state <= fr_gcd_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= fr_gcd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // ---- output register ------------------------------------------------------
  logic load_out;
  assign load_out = (state == fr_gcd_pkg::ST_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_num  <= rn;
      out_den  <= rd;
      out_g    <= g;
      out_flag <= flag;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_g, out_den, out_num};
  assign m_tuser  = out_flag;

  // ---- assertions -----------------------------------------------------------
  `ASSERT_PROP(a_flag_needs_gcd, (m_tvalid && m_tuser) |-> (out_g > W'(1)))
  `ASSERT_PROP(a_zero_den_zero_gcd, (m_tvalid && out_den == '0) |-> (out_g == '0 && !m_tuser))
  `ASSERT_NEVER(a_k_overflow, state == fr_gcd_pkg::ST_GCD && a != '0 && !a[0] && !b[0]
                 && k == fr_gcd_pkg::KW'(W - 1))
  `ASSERT_PROP(a_gcd_ends, (state == fr_gcd_pkg::ST_GCD && a == '0)
                 |=> (state == fr_gcd_pkg::ST_DECIDE))
  `ASSERT_NEVER(a_b_zero_in_gcd, state == fr_gcd_pkg::ST_GCD && b == '0)

endmodule
